// File: rtl/rcfs_pkg.sv
// Shared types and constants for the RC link frame sync decoder.
// Used by every module in rtl/; depends on nothing else.
package rcfs_pkg;

  // Link phases. The spare code never occurs, and it decodes as the starting phase.
  typedef enum logic [1:0] {
    PH_START  = 2'd0,
    PH_UPDATE = 2'd1,
    PH_DATA   = 2'd2
  } phase_t;

  // Receive event codes.
  localparam logic [2:0] RX_NONE     = 3'd0;
  localparam logic [2:0] RX_STARTED  = 3'd1;
  localparam logic [2:0] RX_DATA     = 3'd2;
  localparam logic [2:0] RX_COMMAND  = 3'd3;
  localparam logic [2:0] RX_BAD_FRAME = 3'd4;
  localparam logic [2:0] RX_BAD_SIZE = 3'd5;

  // Timing event codes.
  localparam logic [1:0] TM_NONE   = 2'd0;
  localparam logic [1:0] TM_RESYNC = 2'd1;
  localparam logic [1:0] TM_LOST   = 2'd2;
  localparam logic [1:0] TM_SPEED  = 2'd3;

  // Configuration register indexes.
  localparam logic [1:0] CFG_ID_LOW  = 2'd0;
  localparam logic [1:0] CFG_ID_HIGH = 2'd1;
  localparam logic [1:0] CFG_PERIOD  = 2'd2;

  // Frame format and link timing constants.
  localparam logic [5:0]  FRAME_LEN_WITH_STATUS = 6'd13;
  localparam logic [7:0]  FRAME_LEN_BYTE        = 8'd10;
  localparam logic [18:0] DEFAULT_GAP_US        = 19'd50000;
  localparam logic [23:0] DEFAULT_GAP50_US      = 24'd2500000;
  localparam logic [31:0] DEFAULT_SWITCH_US     = 32'd2000000;
  localparam logic [9:0]  FAST_UNIT_US          = 10'd100;
  localparam logic [9:0]  SLOW_UNIT_US          = 10'd1000;
  localparam logic [5:0]  RESYNC_GAPS           = 6'd50;

  // Outcome of the frame check and unpack for one poll.
  typedef struct packed {
    logic        good;
    logic        bad_frame;
    logic        bad_size;
    logic        command;
    logic [10:0] stick_a;
    logic [10:0] stick_b;
    logic [10:0] stick_c;
    logic [10:0] stick_d;
    logic [11:0] switch_bits;
  } frame_t;

  // Link status produced by the state update for one poll.
  typedef struct packed {
    logic [2:0] receive_event;
    logic [1:0] timing_event;
    logic       hop_and_listen;
    logic       swap_antenna;
    logic       fast_mode;
  } link_t;

endpackage

// File: rtl/rcfs_frame_unpack.sv
// Frame check and channel unpack: validates length and transmitter id and
// splits the channel bytes into sticks and switches. Depends on rcfs_pkg.
module rcfs_frame_unpack (
  input  logic [5:0]      received_length,
  input  logic [7:0]      length_byte,
  input  logic [7:0]      id_byte_low,
  input  logic [7:0]      id_byte_high,
  input  logic [55:0]     channel_bytes,
  input  logic [7:0]      id_low,
  input  logic [7:0]      id_high,
  output rcfs_pkg::frame_t frame
);

  logic [7:0] b0, b1, b2, b3, b4, b5, b6;
  logic       size_ok;

  assign b0 = channel_bytes[7:0];
  assign b1 = channel_bytes[15:8];
  assign b2 = channel_bytes[23:16];
  assign b3 = channel_bytes[31:24];
  assign b4 = channel_bytes[39:32];
  assign b5 = channel_bytes[47:40];
  assign b6 = channel_bytes[55:48];

  // Size, header and id checks.
  assign size_ok = (received_length == rcfs_pkg::FRAME_LEN_WITH_STATUS);
  assign frame.good = size_ok && (length_byte == rcfs_pkg::FRAME_LEN_BYTE) &&
                      (id_byte_low == id_low) && (id_byte_high == id_high);
  assign frame.bad_frame = size_ok && !frame.good;
  assign frame.bad_size  = !size_ok && (received_length != 6'd0);

  // A command frame is marked by a first channel byte of one and a zero second byte.
  assign frame.command = (b0 == 8'd1) && (b1 == 8'd0);

  // Four 11-bit sticks packed in two groups of three bytes, switches in the spare bits and the seventh byte.
  assign frame.stick_a     = {b1[2:0], b0};
  assign frame.stick_b     = {b2[6:0], b1[7:4]};
  assign frame.stick_c     = {b4[2:0], b3};
  assign frame.stick_d     = {b5[6:0], b4[7:4]};
  assign frame.switch_bits = {b6, b5[7], b4[3], b2[7], b1[3]};

endmodule

// File: rtl/rcfs_link_state.sv
// Link state registers and per-poll update: phase, speed, frame gap, lost count
// and the three timestamps, plus the receive and timing events. Depends on rcfs_pkg.
module rcfs_link_state (
  input  logic             clk,
  input  logic             rst,
  input  logic             advance,
  input  logic [31:0]      now_us,
  input  logic [7:0]       sync_byte,
  input  rcfs_pkg::frame_t frame,
  input  logic [31:0]      switch_period,
  output rcfs_pkg::link_t  status
);

  rcfs_pkg::phase_t phase, phase_next;
  logic        fast_flag, fast_flag_next;
  logic [18:0] frame_gap, frame_gap_next;
  logic [23:0] frame_gap50, frame_gap50_next;
  logic [1:0]  lost_count, lost_count_next;
  logic [31:0] last_frame_time, last_frame_time_next;
  logic        last_frame_valid, last_frame_valid_next;
  logic [31:0] sync_start_time, sync_start_time_next;
  logic [31:0] speed_start_time, speed_start_time_next;

  logic [17:0] sync_gap;
  logic [18:0] learned_gap;
  logic [31:0] since_sync, since_frame, since_speed;
  logic        resync_hit, lost_hit, speed_hit, in_update;

  // Gap learned from the sync byte, plus one eighth; 50 gaps kept alongside it.
  assign sync_gap    = 18'(sync_byte * (fast_flag ? rcfs_pkg::FAST_UNIT_US
                                                  : rcfs_pkg::SLOW_UNIT_US));
  assign learned_gap = {1'b0, sync_gap} + 19'(sync_gap >> 3);

  // Elapsed times, all modulo 2^32.
  assign since_sync  = now_us - sync_start_time;
  assign since_frame = now_us - last_frame_time;
  assign since_speed = now_us - speed_start_time;

  // In the update phase the sync start and last-frame mark are reloaded first,
  // so neither resync nor frame lost can fire on that poll.
  assign in_update  = (phase == rcfs_pkg::PH_UPDATE);
  assign resync_hit = !in_update && (since_sync > {8'd0, frame_gap50});
  assign lost_hit   = !in_update && last_frame_valid && (since_frame > {13'd0, frame_gap});
  assign speed_hit  = since_speed > switch_period;

  // Next-state and event logic for the poll in the input register.
  always_comb begin
    phase_next            = phase;
    fast_flag_next        = fast_flag;
    frame_gap_next        = frame_gap;
    frame_gap50_next      = frame_gap50;
    lost_count_next       = lost_count;
    last_frame_time_next  = last_frame_time;
    last_frame_valid_next = last_frame_valid;
    sync_start_time_next  = sync_start_time;
    speed_start_time_next = speed_start_time;
    status.receive_event  = rcfs_pkg::RX_NONE;
    status.timing_event   = rcfs_pkg::TM_NONE;
    status.hop_and_listen = 1'b0;
    status.swap_antenna   = 1'b0;
    unique case (phase)
      rcfs_pkg::PH_UPDATE, rcfs_pkg::PH_DATA: begin
        phase_next = rcfs_pkg::PH_DATA;
        if (in_update) begin
          last_frame_valid_next = 1'b0;
          sync_start_time_next  = now_us;
        end
        if (frame.good) begin
          // A good frame restarts every timer, so no timing event follows it.
          frame_gap_next        = learned_gap;
          frame_gap50_next      = 24'(learned_gap * rcfs_pkg::RESYNC_GAPS);
          last_frame_time_next  = now_us;
          last_frame_valid_next = 1'b1;
          sync_start_time_next  = now_us;
          speed_start_time_next = now_us;
          lost_count_next       = 2'd0;
          status.hop_and_listen = 1'b1;
          status.receive_event  = frame.command ? rcfs_pkg::RX_COMMAND : rcfs_pkg::RX_DATA;
        end else begin
          if (frame.bad_frame) begin
            status.receive_event = rcfs_pkg::RX_BAD_FRAME;
          end else if (frame.bad_size) begin
            status.receive_event = rcfs_pkg::RX_BAD_SIZE;
          end
          // Timing checks in order of precedence.
          priority if (resync_hit) begin
            status.timing_event   = rcfs_pkg::TM_RESYNC;
            status.hop_and_listen = 1'b1;
            phase_next            = rcfs_pkg::PH_UPDATE;
          end else if (lost_hit) begin
            status.timing_event   = rcfs_pkg::TM_LOST;
            status.hop_and_listen = 1'b1;
            status.swap_antenna   = lost_count[1];
            last_frame_time_next  = now_us;
            if (lost_count != 2'd3) begin
              lost_count_next = lost_count + 2'd1;
            end
          end else if (speed_hit) begin
            status.timing_event   = rcfs_pkg::TM_SPEED;
            fast_flag_next        = !fast_flag;
            frame_gap_next        = rcfs_pkg::DEFAULT_GAP_US;
            frame_gap50_next      = rcfs_pkg::DEFAULT_GAP50_US;
            speed_start_time_next = now_us;
            phase_next            = rcfs_pkg::PH_START;
          end else begin
            status.timing_event = rcfs_pkg::TM_NONE;
          end
        end
      end
      default: begin
        // Starting phase: announce the start and arm the speed timer.
        phase_next            = rcfs_pkg::PH_UPDATE;
        speed_start_time_next = now_us;
        status.receive_event  = rcfs_pkg::RX_STARTED;
        status.hop_and_listen = 1'b1;
      end
    endcase
    status.fast_mode = fast_flag_next;
  end

  // State registers, updated once per poll as it moves to the result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= rcfs_pkg::PH_START;
      fast_flag        <= 1'b1;
      frame_gap        <= rcfs_pkg::DEFAULT_GAP_US;
      frame_gap50      <= rcfs_pkg::DEFAULT_GAP50_US;
      lost_count       <= 2'd0;
      last_frame_time  <= 32'd0;
      last_frame_valid <= 1'b0;
      sync_start_time  <= 32'd0;
      speed_start_time <= 32'd0;
    end else if (advance) begin
      phase            <= phase_next;
      fast_flag        <= fast_flag_next;
      frame_gap        <= frame_gap_next;
      frame_gap50      <= frame_gap50_next;
      lost_count       <= lost_count_next;
      last_frame_time  <= last_frame_time_next;
      last_frame_valid <= last_frame_valid_next;
      sync_start_time  <= sync_start_time_next;
      speed_start_time <= speed_start_time_next;
    end
  end

endmodule

// File: rtl/rc_link_frame_sync_decoder.sv
// RC link frame sync decoder: one poll of the radio in, one status beat out.
// A poll is taken into an input register, checked and unpacked, and its result
// lands in an output register once that register is free, which offers the status
// beat; the block takes one poll per cycle while the status receiver does not stall.
// The per-poll link state update (phase, speed, gap, lost count, timestamps) is a
// single registered step, which sets that rate.
// The configuration port is always ready; write it only while no poll is in flight.
// Depends on rcfs_pkg, rcfs_frame_unpack and rcfs_link_state.
module rc_link_frame_sync_decoder (
  input  logic        clk,
  input  logic        rst,
  // Configuration writes.
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  // Poll input channel.
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] now_us,
  input  logic [5:0]  received_length,
  input  logic [7:0]  length_byte,
  input  logic [7:0]  id_byte_low,
  input  logic [7:0]  id_byte_high,
  input  logic [55:0] channel_bytes,
  input  logic [7:0]  sync_byte,
  // Status output channel.
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  receive_event,
  output logic [1:0]  timing_event,
  output logic [10:0] stick_a,
  output logic [10:0] stick_b,
  output logic [10:0] stick_c,
  output logic [10:0] stick_d,
  output logic [11:0] switch_bits,
  output logic        hop_and_listen,
  output logic        swap_antenna,
  output logic        fast_mode
);

  logic [7:0]  id_low, id_high;
  logic [31:0] switch_period;

  logic        in_full, advance, in_take;
  logic [31:0] now_q;
  logic [5:0]  len_q;
  logic [7:0]  lbyte_q, idl_q, idh_q, sync_q;
  logic [55:0] chan_q;

  rcfs_pkg::frame_t frame;
  rcfs_pkg::link_t  status;
  logic             is_data;

  // Configuration registers.
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      id_low        <= 8'd0;
      id_high       <= 8'd0;
      switch_period <= rcfs_pkg::DEFAULT_SWITCH_US;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        rcfs_pkg::CFG_ID_LOW:  id_low        <= cfg_data[7:0];
        rcfs_pkg::CFG_ID_HIGH: id_high       <= cfg_data[7:0];
        rcfs_pkg::CFG_PERIOD:  switch_period <= cfg_data;
        default: ;
      endcase
    end
  end

  // Handshake: the input register moves on whenever the output register is free.
  assign advance  = in_full && (!out_valid || !out_stall);
  assign in_stall = in_full && !advance;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_take) begin
      in_full <= 1'b1;
    end else if (advance) begin
      in_full <= 1'b0;
    end
  end

  // Input register payload.
  always_ff @(posedge clk) begin
    if (in_take) begin
      now_q   <= now_us;
      len_q   <= received_length;
      lbyte_q <= length_byte;
      idl_q   <= id_byte_low;
      idh_q   <= id_byte_high;
      chan_q  <= channel_bytes;
      sync_q  <= sync_byte;
    end
  end

  rcfs_frame_unpack u_unpack (
    .received_length (len_q),
    .length_byte     (lbyte_q),
    .id_byte_low     (idl_q),
    .id_byte_high    (idh_q),
    .channel_bytes   (chan_q),
    .id_low          (id_low),
    .id_high         (id_high),
    .frame           (frame)
  );

  rcfs_link_state u_state (
    .clk           (clk),
    .rst           (rst),
    .advance       (advance),
    .now_us        (now_q),
    .sync_byte     (sync_q),
    .frame         (frame),
    .switch_period (switch_period),
    .status        (status)
  );

  // Stick and switch fields only carry a data frame; they read zero otherwise.
  assign is_data = (status.receive_event == rcfs_pkg::RX_DATA);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // Output register payload.
  always_ff @(posedge clk) begin
    if (advance) begin
      receive_event  <= status.receive_event;
      timing_event   <= status.timing_event;
      hop_and_listen <= status.hop_and_listen;
      swap_antenna   <= status.swap_antenna;
      fast_mode      <= status.fast_mode;
      stick_a        <= is_data ? frame.stick_a : 11'd0;
      stick_b        <= is_data ? frame.stick_b : 11'd0;
      stick_c        <= is_data ? frame.stick_c : 11'd0;
      stick_d        <= is_data ? frame.stick_d : 11'd0;
      switch_bits    <= is_data ? frame.switch_bits : 12'd0;
    end
  end

  // A start beat carries a hop and never a timing event.
  a_start_hops: assert property (@(posedge clk) disable iff (rst)
    out_valid && receive_event == rcfs_pkg::RX_STARTED |->
      hop_and_listen && timing_event == rcfs_pkg::TM_NONE)
    else $error("start beat without hop or with a timing event");

  // A good frame restarts all timers, so it never comes with a timing event.
  a_frame_no_timing: assert property (@(posedge clk) disable iff (rst)
    out_valid && (receive_event == rcfs_pkg::RX_DATA ||
                  receive_event == rcfs_pkg::RX_COMMAND) |->
      hop_and_listen && timing_event == rcfs_pkg::TM_NONE)
    else $error("good frame beat with a timing event or without hop");

  // The antenna is only swapped on a lost frame.
  a_swap_on_lost: assert property (@(posedge clk) disable iff (rst)
    out_valid && swap_antenna |-> timing_event == rcfs_pkg::TM_LOST)
    else $error("antenna swap outside a lost frame");

  // The link speed changes only with a speed switch event.
  a_speed_toggle: assert property (@(posedge clk) disable iff (rst)
    $past(advance) && $past(out_valid) && advance && out_valid ##1
      fast_mode != $past(fast_mode) |-> timing_event == rcfs_pkg::TM_SPEED)
    else $error("link speed changed without a speed switch");

endmodule

// File: verif/tb_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for the RC link frame sync decoder. It drives radio polls,
// predicts every status beat from its own copy of the link state and compares them.
// Depends on rcfs_pkg and the rc_link_frame_sync_decoder RTL.
module tb_top;
  import rcfs_pkg::*;

  // The register index past the last real register; writes to it are dropped.
  localparam logic [1:0] CFG_SPARE = 2'd3;
  localparam int DRAIN_CYCLES = 4;
  localparam int DRAIN_LIMIT = 5000;
  localparam int HOLD_CYCLES = 300;
  localparam int ITEMS_PER_SETTING = 262;
  localparam int NUM_SETTINGS = 6;
  localparam longint RUN_LIMIT_NS = 2_000_000;

  // One poll of the radio, in port order.
  typedef struct packed {
    logic [31:0] now_us;
    logic [5:0]  received_length;
    logic [7:0]  length_byte;
    logic [7:0]  id_byte_low;
    logic [7:0]  id_byte_high;
    logic [55:0] channel_bytes;
    logic [7:0]  sync_byte;
  } poll_t;

  // One status beat, in port order.
  typedef struct packed {
    logic [2:0]  receive_event;
    logic [1:0]  timing_event;
    logic [10:0] stick_a;
    logic [10:0] stick_b;
    logic [10:0] stick_c;
    logic [10:0] stick_d;
    logic [11:0] switch_bits;
    logic        hop_and_listen;
    logic        swap_antenna;
    logic        fast_mode;
  } status_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [31:0] now_us = '0;
  logic [5:0]  received_length = '0;
  logic [7:0]  length_byte = '0;
  logic [7:0]  id_byte_low = '0;
  logic [7:0]  id_byte_high = '0;
  logic [55:0] channel_bytes = '0;
  logic [7:0]  sync_byte = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  receive_event;
  logic [1:0]  timing_event;
  logic [10:0] stick_a;
  logic [10:0] stick_b;
  logic [10:0] stick_c;
  logic [10:0] stick_d;
  logic [11:0] switch_bits;
  logic        hop_and_listen;
  logic        swap_antenna;
  logic        fast_mode;

  rc_link_frame_sync_decoder uut (
    .clk(clk),
    .rst(rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .now_us(now_us),
    .received_length(received_length),
    .length_byte(length_byte),
    .id_byte_low(id_byte_low),
    .id_byte_high(id_byte_high),
    .channel_bytes(channel_bytes),
    .sync_byte(sync_byte),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .receive_event(receive_event),
    .timing_event(timing_event),
    .stick_a(stick_a),
    .stick_b(stick_b),
    .stick_c(stick_c),
    .stick_d(stick_d),
    .switch_bits(switch_bits),
    .hop_and_listen(hop_and_listen),
    .swap_antenna(swap_antenna),
    .fast_mode(fast_mode)
  );

  // Register copies and link state of the predictor.
  logic [7:0]  bound_id_low = '0;
  logic [7:0]  bound_id_high = '0;
  logic [31:0] switch_period = DEFAULT_SWITCH_US;
  phase_t      lk_phase = PH_START;
  logic        lk_fast = 1'b1;
  logic [31:0] lk_gap = 32'(DEFAULT_GAP_US);
  logic [1:0]  lk_lost = '0;
  logic [31:0] lk_last_time = '0;
  logic        lk_last_valid = 1'b0;
  logic [31:0] lk_sync_start = '0;
  logic [31:0] lk_speed_start = '0;

  // Stimulus and scoreboard bookkeeping.
  poll_t       pending_polls[$];
  status_t     pending_status[$];
  poll_t       cur_poll = '0;
  logic        poll_accepted = 1'b0;
  logic        quiet_run = 1'b0;
  int          sink_hold_left = 0;
  int          polls_pushed = 0;
  int          polls_taken = 0;
  int          results_checked = 0;
  int          fail_count = 0;
  int          settings_used = 0;
  int          rx_count[8];
  int          tm_count[4];
  logic [31:0] gen_time = '0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Advance the link state by one poll and return the status beat it produces.
  function automatic status_t decode_poll(input poll_t p);
    status_t     s;
    logic [7:0]  b [7];
    logic [31:0] g;
    logic [31:0] resync_limit;
    logic        got;
    s = '0;
    got = 1'b0;
    if (lk_phase != PH_UPDATE && lk_phase != PH_DATA) begin
      lk_phase = PH_UPDATE;
      lk_speed_start = p.now_us;
      s.receive_event = RX_STARTED;
      s.hop_and_listen = 1'b1;
    end else begin
      if (lk_phase == PH_UPDATE) begin
        lk_last_valid = 1'b0;
        lk_sync_start = p.now_us;
        lk_phase = PH_DATA;
      end
      // Frame check: size, length byte and bound id.
      if (p.received_length == FRAME_LEN_WITH_STATUS) begin
        if (p.length_byte == FRAME_LEN_BYTE && p.id_byte_low == bound_id_low &&
            p.id_byte_high == bound_id_high) begin
          g = 32'(p.sync_byte) * 32'(lk_fast ? FAST_UNIT_US : SLOW_UNIT_US);
          lk_gap = g + (g >> 3);
          lk_last_time = p.now_us;
          lk_last_valid = 1'b1;
          lk_sync_start = p.now_us;
          lk_speed_start = p.now_us;
          lk_lost = '0;
          s.hop_and_listen = 1'b1;
          got = 1'b1;
        end else begin
          s.receive_event = RX_BAD_FRAME;
        end
      end else if (p.received_length != '0) begin
        s.receive_event = RX_BAD_SIZE;
      end

      // Unpack the channel bytes of a good frame.
      if (got) begin
        for (int k = 0; k < 7; k++) b[k] = p.channel_bytes[8*k +: 8];
        if (b[0] == 8'd1 && b[1] == 8'd0) begin
          s.receive_event = RX_COMMAND;
        end else begin
          s.receive_event = RX_DATA;
          s.stick_a = {b[1][2:0], b[0]};
          s.stick_b = {b[2][6:0], b[1][7:4]};
          s.stick_c = {b[4][2:0], b[3]};
          s.stick_d = {b[5][6:0], b[4][7:4]};
          s.switch_bits = {b[6], b[5][7], b[4][3], b[2][7], b[1][3]};
        end
      end

      // Timing checks, first match wins; differences wrap at 32 bits.
      resync_limit = 32'(RESYNC_GAPS) * lk_gap;
      if (32'(p.now_us - lk_sync_start) > resync_limit) begin
        s.timing_event = TM_RESYNC;
        s.hop_and_listen = 1'b1;
        lk_phase = PH_UPDATE;
      end else if (lk_last_valid && 32'(p.now_us - lk_last_time) > lk_gap) begin
        s.timing_event = TM_LOST;
        lk_last_time = p.now_us;
        s.hop_and_listen = 1'b1;
        if (lk_lost >= 2'd2) s.swap_antenna = 1'b1;
        if (lk_lost != 2'd3) lk_lost = lk_lost + 2'd1;
      end else if (32'(p.now_us - lk_speed_start) > switch_period) begin
        s.timing_event = TM_SPEED;
        lk_fast = ~lk_fast;
        lk_gap = 32'(DEFAULT_GAP_US);
        lk_speed_start = p.now_us;
        lk_phase = PH_START;
      end
    end
    s.fast_mode = lk_fast;
    return s;
  endfunction

  function automatic void check_field(input string name, input logic [31:0] exp_v,
                                      input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      fail_count++;
    end
  endfunction

  function automatic logic [55:0] rand_bytes();
    logic [63:0] w;
    w = {$urandom, $urandom};
    return w[55:0];
  endfunction

  // Channel bytes that mark a command frame: byte 0 is 1 and byte 1 is 0.
  function automatic logic [55:0] command_bytes();
    logic [55:0] r;
    r = rand_bytes();
    return {r[55:16], 8'h00, 8'h01};
  endfunction

  task automatic push_poll(input logic [31:0] t, input logic [5:0] len,
                           input logic [7:0] lbyte, input logic [7:0] idl,
                           input logic [7:0] idh, input logic [55:0] ch,
                           input logic [7:0] sync);
    pending_polls.push_back('{t, len, lbyte, idl, idh, ch, sync});
    polls_pushed++;
  endtask

  // A poll with an empty fifo; the packet bytes are junk and must be ignored.
  task automatic push_empty(input logic [31:0] t);
    push_poll(t, 6'd0, 8'($urandom), 8'($urandom), 8'($urandom), rand_bytes(),
              8'($urandom));
  endtask

  task automatic push_frame(input logic [31:0] t, input logic [55:0] ch,
                            input logic [7:0] sync);
    push_poll(t, FRAME_LEN_WITH_STATUS, FRAME_LEN_BYTE, bound_id_low, bound_id_high,
              ch, sync);
  endtask

  // Register write over the configuration channel, mirrored into the predictor.
  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_ID_LOW:  bound_id_low = val[7:0];
      CFG_ID_HIGH: bound_id_high = val[7:0];
      CFG_PERIOD:  switch_period = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Wait until every queued poll was taken and every status beat came back.
  task automatic wait_drained();
    int waited;
    waited = 0;
    while ((polls_taken != polls_pushed || pending_status.size() != 0) &&
           waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (waited >= DRAIN_LIMIT) begin
      $error("%0d polls not taken and %0d status beats still expected",
             polls_pushed - polls_taken, pending_status.size());
      fail_count++;
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Random link traffic: mostly frame runs with polling in between, plus
  // silences, broken frames and raw noise.
  task automatic gen_traffic(input int n);
    int          done;
    int          kind;
    int          nfr;
    int          nempty;
    int          gap_nom;
    int          span;
    logic [7:0]  sync;
    logic [5:0]  len;
    logic [7:0]  lb;
    logic [7:0]  il;
    logic [7:0]  ih;
    logic [55:0] ch;
    done = 0;
    while (done < n) begin
      kind = $urandom_range(0, 99);
      if (kind < 60) begin
        // A run of good frames; now and then frames go missing.
        sync = ($urandom_range(0, 19) == 0) ? 8'($urandom_range(0, 255))
                                            : 8'($urandom_range(1, 40));
        gap_nom = (sync == 8'd0) ? 100 : 100 * int'(sync);
        nfr = $urandom_range(3, 12);
        for (int k = 0; k < nfr; k++) begin
          nempty = $urandom_range(0, 3);
          if ($urandom_range(0, 9) == 0) nempty += $urandom_range(3, 10);
          for (int j = 0; j < nempty; j++) begin
            gen_time += $urandom_range(gap_nom / 10 + 1, gap_nom / 4 + 1);
            push_empty(gen_time);
            done++;
          end
          gen_time += $urandom_range(gap_nom / 8 + 1, gap_nom / 2 + 1);
          ch = ($urandom_range(0, 9) == 0) ? command_bytes() : rand_bytes();
          push_frame(gen_time, ch, sync);
          done++;
        end
      end else if (kind < 75) begin
        // Silence of varying length: lost frames, resync or a speed switch.
        nempty = $urandom_range(2, 8);
        case ($urandom_range(0, 3))
          0: span = 2000;
          1: span = 60000;
          2: span = 400000;
          default: span = 3000000;
        endcase
        for (int j = 0; j < nempty; j++) begin
          gen_time += $urandom_range(1, span);
          push_empty(gen_time);
          done++;
        end
      end else if (kind < 90) begin
        // A frame with one thing wrong.
        len = FRAME_LEN_WITH_STATUS;
        lb = FRAME_LEN_BYTE;
        il = bound_id_low;
        ih = bound_id_high;
        case ($urandom_range(0, 3))
          0: lb = lb ^ 8'($urandom_range(1, 255));
          1: il = il ^ 8'($urandom_range(1, 255));
          2: ih = ih ^ 8'($urandom_range(1, 255));
          default: begin
            len = 6'($urandom_range(1, 62));
            if (len >= FRAME_LEN_WITH_STATUS) len = len + 6'd1;
          end
        endcase
        gen_time += $urandom_range(1, 500);
        push_poll(gen_time, len, lb, il, ih, rand_bytes(), 8'($urandom_range(0, 255)));
        done++;
      end else begin
        // Raw noise on every field, sometimes with a jump to any time at all.
        if ($urandom_range(0, 3) == 0) gen_time = $urandom;
        else gen_time += $urandom_range(1, 100000);
        push_poll(gen_time, 6'($urandom_range(0, 63)), 8'($urandom), 8'($urandom),
                  8'($urandom), rand_bytes(), 8'($urandom));
        done++;
      end
    end
  endtask

  // Poll driver: presents the next queued poll once the current beat is taken.
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || poll_accepted) begin
      if (pending_polls.size() != 0 && (quiet_run || $urandom_range(0, 99) >= 9)) begin
        cur_poll = pending_polls.pop_front();
        in_valid <= 1'b1;
        {now_us, received_length, length_byte, id_byte_low, id_byte_high,
         channel_bytes, sync_byte} <= cur_poll;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Status receiver: random stalls, or a counted hold-off when one is requested.
  always @(negedge clk) begin
    if (sink_hold_left > 0) begin
      out_stall <= 1'b1;
      sink_hold_left--;
    end else begin
      out_stall <= !quiet_run && ($urandom_range(0, 99) < 9);
    end
  end

  // Monitor: predicts each accepted poll and checks each accepted status beat.
  always @(posedge clk) begin
    status_t want;
    status_t seen;
    poll_accepted = 1'b0;
    if (!rst) begin
      if (in_valid && !in_stall) begin
        pending_status.push_back(decode_poll(cur_poll));
        polls_taken++;
        poll_accepted = 1'b1;
      end
      if (out_valid && !out_stall) begin
        seen = {receive_event, timing_event, stick_a, stick_b, stick_c, stick_d,
                switch_bits, hop_and_listen, swap_antenna, fast_mode};
        if (pending_status.size() == 0) begin
          $error("status beat with no poll waiting for it");
          fail_count++;
        end else begin
          want = pending_status.pop_front();
          check_field("receive_event", 32'(want.receive_event), 32'(seen.receive_event));
          check_field("timing_event", 32'(want.timing_event), 32'(seen.timing_event));
          check_field("stick_a", 32'(want.stick_a), 32'(seen.stick_a));
          check_field("stick_b", 32'(want.stick_b), 32'(seen.stick_b));
          check_field("stick_c", 32'(want.stick_c), 32'(seen.stick_c));
          check_field("stick_d", 32'(want.stick_d), 32'(seen.stick_d));
          check_field("switch_bits", 32'(want.switch_bits), 32'(seen.switch_bits));
          check_field("hop_and_listen", 32'(want.hop_and_listen),
                      32'(seen.hop_and_listen));
          check_field("swap_antenna", 32'(want.swap_antenna), 32'(seen.swap_antenna));
          check_field("fast_mode", 32'(want.fast_mode), 32'(seen.fast_mode));
          rx_count[want.receive_event]++;
          tm_count[want.timing_event]++;
          results_checked++;
        end
      end
    end
  end

  // Main sequence: reset, directed polls, then random traffic under several settings.
  initial begin
    logic [31:0] period;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    write_reg(CFG_ID_LOW, 32'h0000_005A);
    write_reg(CFG_ID_HIGH, 32'h0000_00C3);
    write_reg(CFG_PERIOD, 32'd20000);
    settings_used++;
    @(posedge clk);

    // Startup, then data frames with all-ones and all-zero bytes, and a command frame.
    push_empty(32'd1000);
    push_frame(32'd1100, {56{1'b1}}, 8'd10);
    push_frame(32'd1500, 56'd0, 8'd10);
    push_frame(32'd1900, command_bytes(), 8'd10);
    // Each way a frame can be rejected, and sizes around and far from a full frame.
    push_poll(32'd2000, FRAME_LEN_WITH_STATUS, FRAME_LEN_BYTE + 8'd1, bound_id_low,
              bound_id_high, rand_bytes(), 8'd10);
    push_poll(32'd2100, FRAME_LEN_WITH_STATUS, FRAME_LEN_BYTE, ~bound_id_low,
              bound_id_high, rand_bytes(), 8'd10);
    push_poll(32'd2200, FRAME_LEN_WITH_STATUS, FRAME_LEN_BYTE, bound_id_low,
              ~bound_id_high, rand_bytes(), 8'd10);
    push_poll(32'd2300, FRAME_LEN_WITH_STATUS - 6'd1, FRAME_LEN_BYTE, bound_id_low,
              bound_id_high, rand_bytes(), 8'd10);
    push_poll(32'd2400, 6'd63, 8'hFF, 8'hFF, 8'hFF, {56{1'b1}}, 8'hFF);
    push_poll(32'd2500, 6'd1, 8'h00, 8'h00, 8'h00, 56'd0, 8'h00);
    // Four lost frames in a row: the antenna swaps from the third on.
    push_frame(32'd2600, rand_bytes(), 8'd4);
    push_empty(32'd3100);
    push_empty(32'd3600);
    push_empty(32'd4100);
    push_empty(32'd4600);
    // Resync after fifty gaps, then a speed switch out of the update phase.
    push_empty(32'd25200);
    push_empty(32'd25300);
    push_empty(32'd25400);
    // Largest sync byte in slow mode, then a zero sync byte and the resync it causes.
    push_frame(32'd25500, rand_bytes(), 8'd255);
    push_frame(32'd25600, rand_bytes(), 8'd0);
    push_empty(32'd25700);
    push_empty(32'd25800);
    // Time wraps past zero across frame and speed timestamps.
    push_empty(32'hFFFF_FF00);
    push_empty(32'hFFFF_FFF0);
    push_empty(32'hFFFF_FFF8);
    push_frame(32'hFFFF_FFFC, rand_bytes(), 8'd20);
    push_empty(32'h0000_0100);
    push_frame(32'h0000_0200, rand_bytes(), 8'd255);
    push_empty(32'h0000_0300);
    gen_time = 32'h0000_0300;
    wait_drained();

    for (int p = 0; p < NUM_SETTINGS; p++) begin
      case (p)
        0: begin
          write_reg(CFG_ID_LOW, 32'd0);
          write_reg(CFG_ID_HIGH, 32'd0);
          period = DEFAULT_SWITCH_US;
        end
        1: begin
          write_reg(CFG_ID_LOW, 32'hFFFF_FFFF);
          write_reg(CFG_ID_HIGH, 32'hFFFF_FFFF);
          period = 32'd1;
        end
        default: begin
          if (p == 5) write_reg(CFG_SPARE, $urandom);
          write_reg(CFG_ID_LOW, $urandom);
          write_reg(CFG_ID_HIGH, $urandom);
          case (p)
            2: period = 32'hFFFF_FFFF;
            3: period = $urandom_range(5000, 80000);
            4: period = $urandom_range(1, 3000000);
            default: period = $urandom_range(100, 200000);
          endcase
        end
      endcase
      write_reg(CFG_PERIOD, period);
      settings_used++;
      @(posedge clk);
      quiet_run = (p == 2);
      if (p == 4) gen_time = 32'hFFFF_FFFF - $urandom_range(0, 2000000);
      gen_traffic(ITEMS_PER_SETTING);
      // The receiver holds off while the sender keeps offering polls.
      if (p == 3) sink_hold_left = HOLD_CYCLES;
      wait_drained();
    end

    $display("Checked %0d status beats from %0d polls under %0d register settings.",
             results_checked, polls_taken, settings_used);
    $display("Events: %0d data %0d cmd %0d rejected %0d bad size %0d resync %0d lost %0d switch",
             rx_count[RX_DATA], rx_count[RX_COMMAND], rx_count[RX_BAD_FRAME],
             rx_count[RX_BAD_SIZE], tm_count[TM_RESYNC], tm_count[TM_LOST],
             tm_count[TM_SPEED]);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #(RUN_LIMIT_NS);
    $display("Run did not complete within the time limit.");
    $display("CHECK FAILED");
    $finish;
  end

endmodule

// File: sim.f
rtl/rcfs_pkg.sv
rtl/rcfs_frame_unpack.sv
rtl/rcfs_link_state.sv
rtl/rc_link_frame_sync_decoder.sv
verif/tb_top.sv
